[hw/rtl/srarq_pkg.sv]
// shared constants for the selective-repeat receiver
// item operation codes, mode codes, register indexes, default sizes and register defaults
`timescale 1ns / 1ps

package srarq_pkg;

	localparam int DEF_WINDOW      = 8;
	localparam int DEF_MAX_PAYLOAD = 32;

	localparam logic [1:0] OP_HEADER = 2'd0;
	localparam logic [1:0] OP_BYTE   = 2'd1;
	localparam logic [1:0] OP_SERVE  = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	localparam logic [1:0] MODE_RECEIVING   = 2'd0;
	localparam logic [1:0] MODE_COMPLETED   = 2'd1;
	localparam logic [1:0] MODE_UNCOMPLETED = 2'd2;

	localparam logic [2:0] REG_LOCAL_ADDR = 3'd0;
	localparam logic [2:0] REG_PEER_ADDR  = 3'd1;
	localparam logic [2:0] REG_TICKS      = 3'd2;
	localparam logic [2:0] REG_ACK_CODE   = 3'd3;
	localparam logic [2:0] REG_ARQ_CODE   = 3'd4;

	localparam logic [15:0] DEF_TICKS    = 16'd100;
	localparam logic [7:0]  DEF_ACK_CODE = 8'd1;
	localparam logic [7:0]  DEF_ARQ_CODE = 8'd2;

	typedef logic [23:0] timer_t;

endpackage

[hw/rtl/srarq_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module srarq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/selective_repeat_arq_receiver.sv]
// selective-repeat receiver: window slots, delivery, ack and arq emission
// depends on srarq_pkg and srarq_ram
`timescale 1ns / 1ps

// Usage
// Items enter on start while busy is low: operation selects header, payload
// byte, service step or timer tick, and the other inputs carry the fields.
// Header, payload byte and tick items emit nothing; busy stays low so one
// can follow every cycle.
// A service step with results raises busy until they are out. Each result
// shows on the result ports for one cycle with strobe high; the receiver
// cannot stall; results leave at one per cycle but for arq scan gaps.
// Receiving mode: the slot is looked up, then the message is read from the
// payload ram through its registered read port, one byte a cycle.
// Completed mode: ack of three bytes.
// Uncompleted mode: arq code then a scan of the WINDOW slots, giving the
// high and then the low byte of each missing slot's sequence number; a
// filled slot is skipped with no result.
// Slots rotate over a base pointer so a window slide moves no payload data.
// Reset clears control state; the payload ram is not cleared and needs no
// clearing pass. Configuration writes are always ready.

module selective_repeat_arq_receiver #(
	parameter int WINDOW      = srarq_pkg::DEF_WINDOW,
	parameter int MAX_PAYLOAD = srarq_pkg::DEF_MAX_PAYLOAD
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] seq_num,
	input  logic        is_range,
	input  logic [5:0]  pay_len,
	input  logic [7:0]  in_byte,
	output logic        strobe,
	output logic        kind,
	output logic [15:0] ctrl_seq,
	output logic [7:0]  dest_addr,
	output logic [7:0]  src_addr,
	output logic [7:0]  out_byte,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	import srarq_pkg::*;

	localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW    = $clog2(MAX_PAYLOAD + 1);
	localparam int DEPTH = WINDOW * MAX_PAYLOAD;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DLV  = 3'd1;
	localparam logic [2:0] ST_ACK  = 3'd2;
	localparam logic [2:0] ST_ARQH = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;

	// configuration
	logic [7:0]  local_q, peer_q, ackc_q, arqc_q;
	logic [15:0] ticks_q;

	// window state
	logic [1:0]    mode_q;
	logic [15:0]   ws_q, ne_q, ntd_q, own_q;
	logic [WINDOW-1:0] filled_q;
	logic [CW-1:0] len_q [WINDOW];
	logic [SW-1:0] base_q;
	logic [SW-1:0] fslot_q;
	logic [CW-1:0] fcnt_q;
	logic          factive_q;
	timer_t        timer_q;

	// sequencer
	logic [2:0]    state_q;
	logic [CW-1:0] dcnt_q, dlen_q;
	logic [SW-1:0] dphys_q;
	logic          dlv_s1, dlast_s1;
	logic [1:0]    ack_k_q;
	logic [SW-1:0] scan_q;
	logic          ph_q;
	logic [WINDOW-1:0] miss_q;
	logic [15:0]   snap_q, cseq_q;
	logic          ctl_q, clast_q;
	logic [7:0]    cbyte_q;

	logic          accept;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_rdata;

	function automatic logic [SW-1:0] phys(input logic [SW-1:0] b, input logic [SW-1:0] l);
		logic [SW:0] s;
		s = {1'b0, b} + {1'b0, l};
		if (s >= (SW+1)'(WINDOW)) begin
			s = s - (SW+1)'(WINDOW);
		end
		return s[SW-1:0];
	endfunction

	function automatic logic [AW-1:0] addr(input logic [SW-1:0] p, input logic [CW-1:0] c);
		return AW'(int'(p) * MAX_PAYLOAD + int'(c));
	endfunction

	function automatic timer_t arm(input logic [15:0] t, input logic [SW:0] slots);
		return timer_t'({8'd0, t} * 24'(slots));
	endfunction

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE) || dlv_s1;
	assign cfg_ready = 1'b1;

	// header decode
	logic [15:0]   hidx16;
	logic          hin_win;
	logic [SW-1:0] hidx, hphys;
	logic [CW-1:0] hlen;

	assign hidx16  = seq_num - ws_q;
	assign hin_win = hidx16 < 16'(WINDOW);
	assign hidx    = hidx16[SW-1:0];
	assign hphys   = phys(base_q, hidx);
	assign hlen    = (int'(pay_len) > MAX_PAYLOAD) ? CW'(MAX_PAYLOAD) : CW'(pay_len);

	// byte fill and delivery lookup share one length read
	logic [SW-1:0] fphys, didx, dphys, rd_phys;
	logic [15:0]   didx16;
	logic          dvalid;
	logic [CW-1:0] rlen, fcnt_inc;

	assign fphys    = phys(base_q, fslot_q);
	assign didx16   = ntd_q - ws_q;
	assign didx     = didx16[SW-1:0];
	assign dphys    = phys(base_q, didx);
	assign dvalid   = (didx16 < 16'(WINDOW)) && filled_q[dphys];
	assign rd_phys  = (operation == OP_BYTE) ? fphys : dphys;
	assign rlen     = len_q[rd_phys];
	assign fcnt_inc = fcnt_q + 1'b1;

	// commit of a finished message
	logic          commit;
	logic [SW-1:0] cidx;

	always_comb begin
		commit = 1'b0;
		cidx   = hidx;
		if (accept && operation == OP_HEADER && is_range && hin_win &&
			!filled_q[hphys] && hlen == '0) begin
			commit = 1'b1;
		end
		if (accept && operation == OP_BYTE && factive_q && fcnt_inc == rlen) begin
			commit = 1'b1;
			cidx   = fslot_q;
		end
	end

	// receiving-mode decision after a delivery
	logic [15:0] ntd_next;
	logic        all_filled;

	assign ntd_next   = dvalid ? ntd_q + 16'd1 : ntd_q;
	assign all_filled = &filled_q;

	// uncompleted slide
	logic [15:0]       done16;
	logic [SW:0]       done;
	logic [SW:0]       base_sum;
	logic [WINDOW-1:0] clr_mask, miss_now;
	logic [SW:0]       lpos;

	assign done16   = ntd_q - ws_q;
	assign done     = (done16 > 16'(WINDOW)) ? (SW+1)'(WINDOW) : done16[SW:0];
	assign base_sum = {1'b0, base_q} + done;

	always_comb begin
		for (int p = 0; p < WINDOW; p++) begin
			lpos = ((SW+1)'(p) >= {1'b0, base_q}) ?
				(SW+1)'(p) - {1'b0, base_q} :
				(SW+1)'(p) + (SW+1)'(WINDOW) - {1'b0, base_q};
			clr_mask[p] = lpos < done;
			miss_now[p] = !filled_q[phys(base_q, SW'(p))];
		end
	end

	logic [WINDOW-1:0] miss_above;
	assign miss_above = miss_q >> scan_q;

	logic [15:0] scan_seq;
	assign scan_seq = snap_q + 16'(scan_q);

	assign ram_we    = accept && operation == OP_BYTE && factive_q;
	assign ram_waddr = addr(fphys, fcnt_q);
	assign ram_raddr = addr(dphys_q, dcnt_q);

	srarq_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(in_byte),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept && operation == OP_HEADER && is_range && hin_win && !filled_q[hphys]) begin
			len_q[hphys] <= hlen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q   <= '0;
			peer_q    <= '0;
			ticks_q   <= DEF_TICKS;
			ackc_q    <= DEF_ACK_CODE;
			arqc_q    <= DEF_ARQ_CODE;
			mode_q    <= MODE_RECEIVING;
			ws_q      <= '0;
			ne_q      <= '0;
			ntd_q     <= '0;
			own_q     <= '0;
			filled_q  <= '0;
			base_q    <= '0;
			fslot_q   <= '0;
			fcnt_q    <= '0;
			factive_q <= 1'b0;
			timer_q   <= '0;
			state_q   <= ST_IDLE;
			dcnt_q    <= '0;
			dlen_q    <= '0;
			dphys_q   <= '0;
			dlv_s1    <= 1'b0;
			dlast_s1  <= 1'b0;
			ack_k_q   <= '0;
			scan_q    <= '0;
			ph_q      <= 1'b0;
			miss_q    <= '0;
			snap_q    <= '0;
			cseq_q    <= '0;
			ctl_q     <= 1'b0;
			clast_q   <= 1'b0;
			cbyte_q   <= '0;
		end else begin
			dlv_s1 <= 1'b0;
			ctl_q  <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOCAL_ADDR: local_q <= cfg_data[7:0];
					REG_PEER_ADDR:  peer_q  <= cfg_data[7:0];
					REG_TICKS:      ticks_q <= cfg_data;
					REG_ACK_CODE:   ackc_q  <= cfg_data[7:0];
					REG_ARQ_CODE:   arqc_q  <= cfg_data[7:0];
					default: ;
				endcase
			end

			if (commit) begin
				filled_q[phys(base_q, cidx)] <= 1'b1;
				ne_q    <= ws_q + 16'(cidx) + 16'd1;
				timer_q <= arm(ticks_q, (SW+1)'(WINDOW - 1) - {1'b0, cidx});
			end

			if (accept) begin
				case (operation)
					OP_HEADER: begin
						factive_q <= 1'b0;
						if (is_range && hin_win && !filled_q[hphys]) begin
							fslot_q <= hidx;
							fcnt_q  <= '0;
							if (hlen != '0) begin
								factive_q <= 1'b1;
							end
						end
					end
					OP_BYTE: begin
						if (factive_q) begin
							fcnt_q <= fcnt_inc;
							if (fcnt_inc == rlen) begin
								factive_q <= 1'b0;
							end
						end
					end
					OP_TICK: begin
						if (timer_q != '0) begin
							timer_q <= timer_q - 1'b1;
						end
					end
					default: begin
						if (mode_q == MODE_COMPLETED) begin
							cseq_q    <= own_q;
							own_q     <= own_q + 16'd1;
							ws_q      <= ws_q + 16'(WINDOW);
							ne_q      <= ws_q + 16'(WINDOW);
							ntd_q     <= ws_q + 16'(WINDOW);
							filled_q  <= '0;
							factive_q <= 1'b0;
							timer_q   <= arm(ticks_q, (SW+1)'(WINDOW));
							mode_q    <= MODE_RECEIVING;
							ack_k_q   <= '0;
							state_q   <= ST_ACK;
						end else if (mode_q == MODE_UNCOMPLETED) begin
							cseq_q  <= own_q;
							own_q   <= own_q + 16'd1;
							miss_q  <= miss_now;
							snap_q  <= ws_q;
							if (done != '0) begin
								filled_q <= filled_q & ~clr_mask;
								base_q   <= (base_sum >= (SW+1)'(WINDOW)) ?
									SW'(base_sum - (SW+1)'(WINDOW)) : SW'(base_sum);
								if (factive_q) begin
									if ({1'b0, fslot_q} >= done) begin
										fslot_q <= SW'({1'b0, fslot_q} - done);
									end else begin
										factive_q <= 1'b0;
									end
								end
							end
							ws_q    <= ntd_q;
							ne_q    <= ntd_q;
							timer_q <= arm(ticks_q, (SW+1)'(WINDOW));
							mode_q  <= MODE_RECEIVING;
							state_q <= ST_ARQH;
						end else begin
							ntd_q <= ntd_next;
							if (dvalid && rlen != '0) begin
								dcnt_q  <= '0;
								dlen_q  <= rlen;
								dphys_q <= dphys;
								state_q <= ST_DLV;
							end
							if (all_filled) begin
								if (16'(ntd_next - ws_q) >= 16'(WINDOW)) begin
									mode_q <= MODE_COMPLETED;
								end
							end else if (ne_q == ws_q + 16'(WINDOW) || timer_q == '0) begin
								mode_q <= MODE_UNCOMPLETED;
							end
						end
					end
				endcase
			end

			case (state_q)
				ST_DLV: begin
					dlv_s1   <= 1'b1;
					dlast_s1 <= (dcnt_q == dlen_q - 1'b1);
					if (dcnt_q == dlen_q - 1'b1) begin
						state_q <= ST_IDLE;
					end else begin
						dcnt_q <= dcnt_q + 1'b1;
					end
				end
				ST_ACK: begin
					ctl_q   <= 1'b1;
					clast_q <= (ack_k_q == 2'd2);
					case (ack_k_q)
						2'd0:    cbyte_q <= ackc_q;
						2'd1:    cbyte_q <= ne_q[15:8];
						default: cbyte_q <= ne_q[7:0];
					endcase
					ack_k_q <= ack_k_q + 2'd1;
					if (ack_k_q == 2'd2) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ARQH: begin
					ctl_q   <= 1'b1;
					cbyte_q <= arqc_q;
					clast_q <= (miss_q == '0);
					scan_q  <= '0;
					ph_q    <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (miss_q[scan_q] && !ph_q) begin
						ctl_q   <= 1'b1;
						cbyte_q <= scan_seq[15:8];
						clast_q <= 1'b0;
						ph_q    <= 1'b1;
					end else begin
						// low byte of a missing slot, or a filled slot skipped
						if (miss_q[scan_q]) begin
							ctl_q   <= 1'b1;
							cbyte_q <= scan_seq[7:0];
							clast_q <= (miss_above[WINDOW-1:1] == '0);
						end
						ph_q <= 1'b0;
						if (scan_q == SW'(WINDOW - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign strobe    = dlv_s1 || ctl_q;
	assign kind      = ctl_q;
	assign out_byte  = dlv_s1 ? ram_rdata : cbyte_q;
	assign last      = dlv_s1 ? dlast_s1 : clast_q;
	assign ctrl_seq  = ctl_q ? cseq_q : 16'd0;
	assign dest_addr = ctl_q ? peer_q : 8'd0;
	assign src_addr  = ctl_q ? local_q : 8'd0;

endmodule
